// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL top level.
// Expects a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent on the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

// ----- sv/ldtvc_pkg.sv -----
// Package for the launch detect / TVC sequencer: register codes, reset values,
// servo configuration type and time comparison helper. No dependencies.
package ldtvc_pkg;

  localparam int TIME_BITS = 32;
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [2:0] REG_ACCEL_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_RUN_REQUIRED    = 3'd1;
  localparam logic [2:0] REG_FLIGHT_DURATION = 3'd2;
  localparam logic [2:0] REG_CALIB_INTERVAL  = 3'd3;
  localparam logic [2:0] REG_LOG_INTERVAL    = 3'd4;
  localparam logic [2:0] REG_SERVO_GAIN      = 3'd5;
  localparam logic [2:0] REG_SERVO_MID       = 3'd6;
  localparam logic [2:0] REG_SERVO_RANGE     = 3'd7;

  localparam logic [14:0] RST_ACCEL_THRESHOLD = 15'd2511;
  localparam logic [3:0]  RST_RUN_REQUIRED    = 4'd7;
  localparam logic [31:0] RST_FLIGHT_DURATION = 32'd8000;
  localparam logic [31:0] RST_CALIB_INTERVAL  = 32'd15000;
  localparam logic [15:0] RST_LOG_INTERVAL    = 16'd10;
  localparam logic [7:0]  RST_SERVO_GAIN      = 8'd96;
  localparam logic [7:0]  RST_SERVO_MID       = 8'd90;
  localparam logic [6:0]  RST_SERVO_RANGE     = 7'd30;
  localparam logic [29:0] RST_THRESHOLD_SQ    = 30'(2511 * 2511);

  localparam logic [3:0] RUN_COUNT_MAX = 4'hF;

  typedef struct packed {
    logic [7:0] gain;
    logic [7:0] mid;
    logic [6:0] range;
  } servo_cfg_t;

  // true when (now - then) mod 2^TIME_BITS has reached lim
  function automatic logic interval_due(input logic [TIME_BITS-1:0] now,
                                        input logic [TIME_BITS-1:0] then_t,
                                        input logic [31:0] lim);
    logic [TIME_BITS-1:0] diff;
    diff = now - then_t;
    return CMP_W'(diff) >= CMP_W'(lim);
  endfunction

endpackage

// ----- sv/ldtvc_servo.sv -----
// Servo command: floor(mid + gain*angle/1024), clamped to mid +/- range, then 0..255.
// Depends on ldtvc_pkg (servo_cfg_t).
module ldtvc_servo import ldtvc_pkg::*; (
  input  servo_cfg_t         cfg,
  input  logic signed [15:0] angle,
  output logic [7:0]         cmd
);

  logic signed [24:0] prod;
  logic signed [14:0] quot;
  logic signed [16:0] mid_s;
  logic signed [16:0] raw;
  logic signed [16:0] lo;
  logic signed [16:0] hi;
  logic signed [16:0] clip_hi;
  logic signed [16:0] clip;

  always_comb begin
    prod    = $signed({1'b0, cfg.gain}) * angle;
    quot    = prod[24:10];
    mid_s   = $signed({9'b0, cfg.mid});
    raw     = mid_s + 17'(quot);
    lo      = mid_s - $signed({10'b0, cfg.range});
    hi      = mid_s + $signed({10'b0, cfg.range});
    clip_hi = (raw > hi) ? hi : raw;
    clip    = (clip_hi < lo) ? lo : clip_hi;
    if (clip < 17'sd0) begin
      cmd = 8'd0;
    end else if (clip > 17'sd255) begin
      cmd = 8'd255;
    end else begin
      cmd = clip[7:0];
    end
  end

endmodule

// ----- sv/launch_detect_tvc_sequencer.sv -----
// Launch detect and TVC sequencer top level: config registers, input register,
// per-tick state update and result register. Depends on ldtvc_pkg, ldtvc_servo, assert_macros.svh.
// A tick passes through the input register and then the result register; out_stall can hold it between.
// Throughput: one tick per cycle while out_stall is low; the magnitude squares, servo multiplies and
// time compares all sit between the input register and the result register.
// Reset: synchronous, clears the valid flags, launch/flight state, run count and time stamps,
// and loads every config register with its default.
module launch_detect_tvc_sequencer import ldtvc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        time_ms,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         servo_x,
  output logic [7:0]         servo_y,
  output logic               launch_seen,
  output logic               in_flight,
  output logic               start_logging,
  output logic               stop_logging,
  output logic               calib_request,
  output logic               log_strobe
);

`include "assert_macros.svh"

  // configuration
  logic [29:0] threshold_sq;
  logic [3:0]  run_required;
  logic [31:0] flight_duration_ms;
  logic [31:0] calib_interval_ms;
  logic [15:0] log_interval_ms;
  servo_cfg_t  servo_cfg;

  // block state
  logic                 launch_flag;
  logic                 flight_flag;
  logic [3:0]           over_run_count;
  logic [TIME_BITS-1:0] launch_stamp;
  logic [TIME_BITS-1:0] calib_stamp;
  logic [TIME_BITS-1:0] log_stamp;

  // input register
  logic               s1_valid;
  logic [31:0]        s1_time;
  logic signed [15:0] s1_ax;
  logic signed [15:0] s1_ay;
  logic signed [15:0] s1_az;
  logic signed [15:0] s1_pitch;
  logic signed [15:0] s1_yaw;

  logic out_free;
  logic take;
  logic fire;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_free;
  assign take      = in_valid && !in_stall;
  assign fire      = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_sq       <= RST_THRESHOLD_SQ;
      run_required       <= RST_RUN_REQUIRED;
      flight_duration_ms <= RST_FLIGHT_DURATION;
      calib_interval_ms  <= RST_CALIB_INTERVAL;
      log_interval_ms    <= RST_LOG_INTERVAL;
      servo_cfg.gain     <= RST_SERVO_GAIN;
      servo_cfg.mid      <= RST_SERVO_MID;
      servo_cfg.range    <= RST_SERVO_RANGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACCEL_THRESHOLD: begin
          threshold_sq    <= cfg_data[14:0] * cfg_data[14:0];
        end
        REG_RUN_REQUIRED:    run_required       <= cfg_data[3:0];
        REG_FLIGHT_DURATION: flight_duration_ms <= cfg_data;
        REG_CALIB_INTERVAL:  calib_interval_ms  <= cfg_data;
        REG_LOG_INTERVAL:    log_interval_ms    <= cfg_data[15:0];
        REG_SERVO_GAIN:      servo_cfg.gain     <= cfg_data[7:0];
        REG_SERVO_MID:       servo_cfg.mid      <= cfg_data[7:0];
        REG_SERVO_RANGE:     servo_cfg.range    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_time  <= time_ms;
      s1_ax    <= accel_x;
      s1_ay    <= accel_y;
      s1_az    <= accel_z;
      s1_pitch <= pitch_angle;
      s1_yaw   <= yaw_angle;
    end
  end

  // per-tick evaluation
  logic signed [31:0]   sq_x;
  logic signed [31:0]   sq_y;
  logic signed [31:0]   sq_z;
  logic [31:0]          mag;
  logic [TIME_BITS-1:0] now;
  logic [3:0]           count_next;
  logic                 launch_now;
  logic                 calib_now;
  logic                 flight_eff;
  logic [TIME_BITS-1:0] launch_ref;
  logic                 flight_end;
  logic                 steer;
  logic                 log_now;
  logic [7:0]           cmd_x;
  logic [7:0]           cmd_y;

  ldtvc_servo u_servo_x (
    .cfg   (servo_cfg),
    .angle (s1_pitch),
    .cmd   (cmd_x)
  );

  ldtvc_servo u_servo_y (
    .cfg   (servo_cfg),
    .angle (s1_yaw),
    .cmd   (cmd_y)
  );

  always_comb begin
    sq_x = s1_ax * s1_ax;
    sq_y = s1_ay * s1_ay;
    sq_z = s1_az * s1_az;
    mag  = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
    now  = TIME_BITS'(s1_time);

    count_next = over_run_count;
    if (!launch_flag) begin
      if (mag > {2'b0, threshold_sq}) begin
        count_next = (over_run_count == RUN_COUNT_MAX) ? over_run_count
                                                       : over_run_count + 4'd1;
      end else begin
        count_next = 4'd0;
      end
    end
    launch_now = !launch_flag && (count_next >= run_required);
    calib_now  = !launch_flag && !launch_now &&
                 interval_due(now, calib_stamp, calib_interval_ms);
    flight_eff = flight_flag || launch_now;
    launch_ref = launch_now ? now : launch_stamp;
    flight_end = flight_eff && interval_due(now, launch_ref, flight_duration_ms);
    steer      = flight_eff && !flight_end;
    log_now    = interval_due(now, log_stamp, {16'b0, log_interval_ms});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_flag    <= 1'b0;
      flight_flag    <= 1'b0;
      over_run_count <= 4'd0;
      launch_stamp   <= '0;
      calib_stamp    <= '0;
      log_stamp      <= '0;
    end else if (fire) begin
      over_run_count <= count_next;
      launch_flag    <= launch_flag || launch_now;
      flight_flag    <= steer;
      launch_stamp   <= launch_ref;
      if (calib_now) begin
        calib_stamp <= now;
      end
      if (log_now) begin
        log_stamp <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      servo_x       <= steer ? cmd_x : servo_cfg.mid;
      servo_y       <= steer ? cmd_y : servo_cfg.mid;
      launch_seen   <= launch_flag || launch_now;
      in_flight     <= steer;
      start_logging <= launch_now;
      stop_logging  <= flight_end;
      calib_request <= calib_now;
      log_strobe    <= log_now;
    end
  end

  `ASSERT_ALWAYS(flight_needs_launch, !flight_flag || launch_flag)
  `ASSERT_IMPLIES(start_sets_launch, out_valid && start_logging, launch_seen)
  `ASSERT_IMPLIES(calib_only_prelaunch, out_valid && calib_request, !launch_seen)
  `ASSERT_IMPLIES(stop_clears_flight, out_valid && stop_logging, !in_flight)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for launch_detect_tvc_sequencer: launch detection, calibration
// and log strobes, flight steering with clamping, and flight end; ticks are sent without waiting for earlier results.
// Depends on ldtvc_pkg and the RTL top level only.
module testbench import ldtvc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 5000;

  typedef enum {ACC_UNDER, ACC_OVER, ACC_NOISE} accel_mode_t;

  typedef struct {
    logic [31:0]        time_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } tick_t;

  typedef struct {
    logic [7:0] servo_x;
    logic [7:0] servo_y;
    logic       launch_seen;
    logic       in_flight;
    logic       start_logging;
    logic       stop_logging;
    logic       calib_request;
    logic       log_strobe;
  } tick_status_t;

  typedef struct {
    logic [14:0] thr;
    logic [3:0]  run_req;
    logic [31:0] flight_ms;
    logic [31:0] calib_ms;
    logic [15:0] log_ms;
    logic [7:0]  gain;
    logic [7:0]  mid;
    logic [6:0]  deflect;
  } settings_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        time_ms = '0;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic signed [15:0] pitch_angle = '0;
  logic signed [15:0] yaw_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         servo_x;
  logic [7:0]         servo_y;
  logic               launch_seen;
  logic               in_flight;
  logic               start_logging;
  logic               stop_logging;
  logic               calib_request;
  logic               log_strobe;

  // predicted block state and register shadow
  settings_t   regs;
  logic        launched = 1'b0;
  logic        flying = 1'b0;
  logic [3:0]  run_cnt = '0;
  logic [31:0] launch_at = '0;
  logic [31:0] calib_at = '0;
  logic [31:0] log_at = '0;

  tick_status_t status_due[$];
  tick_status_t head;
  logic [31:0]  clock_ms = '0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           failures = 0;
  int           quiet_cycles = 0;

  launch_detect_tvc_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .time_ms      (time_ms),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .pitch_angle  (pitch_angle),
    .yaw_angle    (yaw_angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .servo_x      (servo_x),
    .servo_y      (servo_y),
    .launch_seen  (launch_seen),
    .in_flight    (in_flight),
    .start_logging(start_logging),
    .stop_logging (stop_logging),
    .calib_request(calib_request),
    .log_strobe   (log_strobe)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic settings_t default_settings();
    settings_t s;
    s.thr       = RST_ACCEL_THRESHOLD;
    s.run_req   = RST_RUN_REQUIRED;
    s.flight_ms = RST_FLIGHT_DURATION;
    s.calib_ms  = RST_CALIB_INTERVAL;
    s.log_ms    = RST_LOG_INTERVAL;
    s.gain      = RST_SERVO_GAIN;
    s.mid       = RST_SERVO_MID;
    s.deflect   = RST_SERVO_RANGE;
    return s;
  endfunction

  function automatic longint accel_mag(tick_t t);
    longint ax, ay, az;
    ax = t.accel_x;
    ay = t.accel_y;
    az = t.accel_z;
    return ax * ax + ay * ay + az * az;
  endfunction

  function automatic logic [3:0] next_run_count(tick_t t);
    longint thr_sq;
    thr_sq = longint'(regs.thr) * longint'(regs.thr);
    if (accel_mag(t) <= thr_sq) return 4'd0;
    return (run_cnt == RUN_COUNT_MAX) ? run_cnt : run_cnt + 4'd1;
  endfunction

  function automatic logic would_launch(tick_t t);
    return !launched && (next_run_count(t) >= regs.run_req);
  endfunction

  // floor(mid + gain * angle / 1024), clamped to mid +/- deflect, then to 0..255
  function automatic logic [7:0] servo_command(logic signed [15:0] angle);
    int prod, cmd, lo, hi;
    prod = int'(regs.gain) * int'(angle);
    cmd  = int'(regs.mid) + (prod >>> 10);
    lo   = int'(regs.mid) - int'(regs.deflect);
    hi   = int'(regs.mid) + int'(regs.deflect);
    if (cmd > hi) cmd = hi;
    if (cmd < lo) cmd = lo;
    if (cmd < 0) cmd = 0;
    if (cmd > 255) cmd = 255;
    return cmd[7:0];
  endfunction

  function automatic tick_status_t predict_status(tick_t t);
    tick_status_t r;
    r = '{default: '0};
    r.servo_x = regs.mid;
    r.servo_y = regs.mid;
    if (!launched) begin
      run_cnt = next_run_count(t);
      if (run_cnt >= regs.run_req) begin
        launched = 1'b1;
        flying = 1'b1;
        launch_at = t.time_ms;
        r.start_logging = 1'b1;
      end else if (32'(t.time_ms - calib_at) >= regs.calib_ms) begin
        r.calib_request = 1'b1;
        calib_at = t.time_ms;
      end
    end
    if (flying) begin
      r.servo_x = servo_command(t.pitch_angle);
      r.servo_y = servo_command(t.yaw_angle);
      if (32'(t.time_ms - launch_at) >= regs.flight_ms) begin
        flying = 1'b0;
        r.stop_logging = 1'b1;
        r.servo_x = regs.mid;
        r.servo_y = regs.mid;
      end
    end
    if (32'(t.time_ms - log_at) >= 32'(regs.log_ms)) begin
      log_at = t.time_ms;
      r.log_strobe = 1'b1;
    end
    r.launch_seen = launched;
    r.in_flight = flying;
    return r;
  endfunction

  function automatic tick_t make_tick(logic [31:0] ms, int ax, int ay, int az, int pa, int ya);
    tick_t t;
    t.time_ms     = ms;
    t.accel_x     = 16'(ax);
    t.accel_y     = 16'(ay);
    t.accel_z     = 16'(az);
    t.pitch_angle = 16'(pa);
    t.yaw_angle   = 16'(ya);
    clock_ms = ms;
    return t;
  endfunction

  function automatic logic [31:0] next_time(logic jumps);
    int pick;
    pick = jumps ? $urandom_range(31) : 31;
    if (pick == 0) clock_ms = $urandom();
    else if (pick == 1) clock_ms = 32'hFFFF_FFF8 + 32'($urandom_range(7));
    else clock_ms = clock_ms + 32'($urandom_range(4));
    return clock_ms;
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(4000)) - 2000);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic tick_t with_accel(tick_t t, accel_mode_t mode);
    int lim, mag;
    t.accel_x = 16'($urandom());
    t.accel_y = 16'($urandom());
    t.accel_z = 16'($urandom());
    if (mode == ACC_UNDER) begin
      // every axis within thr/2 keeps the sum of squares at or below thr^2
      lim = int'(regs.thr) / 2;
      t.accel_x = 16'(int'($urandom_range(2 * lim)) - lim);
      t.accel_y = 16'(int'($urandom_range(2 * lim)) - lim);
      t.accel_z = 16'(int'($urandom_range(2 * lim)) - lim);
    end else if (mode == ACC_OVER) begin
      mag = $urandom_range(32768, int'(regs.thr) + 1);
      if (mag == 32768 || $urandom_range(1) == 1) mag = -mag;
      case ($urandom_range(2))
        0: t.accel_x = 16'(mag);
        1: t.accel_y = 16'(mag);
        default: t.accel_z = 16'(mag);
      endcase
    end
    return t;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    time_ms     <= t.time_ms;
    accel_x     <= t.accel_x;
    accel_y     <= t.accel_y;
    accel_z     <= t.accel_z;
    pitch_angle <= t.pitch_angle;
    yaw_angle   <= t.yaw_angle;
    do @(posedge clk); while (in_stall);
    status_due.push_back(predict_status(t));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input settings_t s);
    wait_results_drained();
    write_reg(REG_ACCEL_THRESHOLD, 32'(s.thr));
    write_reg(REG_RUN_REQUIRED, 32'(s.run_req));
    write_reg(REG_FLIGHT_DURATION, s.flight_ms);
    write_reg(REG_CALIB_INTERVAL, s.calib_ms);
    write_reg(REG_LOG_INTERVAL, 32'(s.log_ms));
    write_reg(REG_SERVO_GAIN, 32'(s.gain));
    write_reg(REG_SERVO_MID, 32'(s.mid));
    write_reg(REG_SERVO_RANGE, 32'(s.deflect));
    cfg_valid <= 1'b0;
    regs = s;
  endtask

  task automatic run_random(input int count, input logic hold_prelaunch, input logic jumps);
    tick_t       t;
    accel_mode_t mode;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) mode = ACC_OVER;
      else if (pick < 85) mode = ACC_UNDER;
      else mode = ACC_NOISE;
      t.time_ms     = next_time(jumps);
      t.pitch_angle = pick_angle();
      t.yaw_angle   = pick_angle();
      t = with_accel(t, mode);
      // keep runs short of launch while the pre-launch logic is exercised
      if (hold_prelaunch && would_launch(t)) t = with_accel(t, ACC_UNDER);
      send_tick(t);
      if (i % 40 == 39) wait_results_drained();
    end
  endtask

  task automatic test_prelaunch_directed();
    settings_t s;
    send_tick(make_tick(32'd0, 0, 0, 0, -32768, 32767));
    send_tick(make_tick(32'd1, -32768, -32768, -32768, 0, 0));
    send_tick(make_tick(32'd2, 32767, 32767, 32767, 0, 0));
    send_tick(make_tick(32'd3, 2511, 0, 0, 0, 0));
    send_tick(make_tick(32'd10, 0, 2512, 0, 0, 0));
    send_tick(make_tick(32'd15000, 0, 0, -2511, 0, 0));
    send_tick(make_tick(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    send_tick(make_tick(32'd3, 0, 0, 0, 0, 0));
    send_tick(make_tick(32'd9, 0, 0, 0, 0, 0));
    s = default_settings();
    s.calib_ms = 32'hFFFF_FFFF;
    s.log_ms = 16'd0;
    apply_settings(s);
    send_tick(make_tick(calib_at - 32'd1, 0, 0, 0, 0, 0));
    send_tick(make_tick(calib_at, 0, 0, 0, 0, 0));
  endtask

  task automatic test_prelaunch_random();
    settings_t plan[4];
    foreach (plan[i]) plan[i] = default_settings();
    plan[0].thr = 15'd0;     plan[0].run_req = 4'd15; plan[0].calib_ms = 32'd0;
    plan[0].log_ms = 16'd0;
    plan[1].thr = 15'h7FFF;  plan[1].run_req = 4'd3;  plan[1].calib_ms = 32'd200;
    plan[1].log_ms = 16'hFFFF; plan[1].mid = 8'd180;
    plan[2].thr = 15'd1500;  plan[2].run_req = 4'd6;  plan[2].calib_ms = 32'd37;
    plan[2].log_ms = 16'd7;  plan[2].mid = 8'd0;
    plan[3].thr = 15'd4000;  plan[3].run_req = 4'd15; plan[3].calib_ms = 32'd5;
    plan[3].log_ms = 16'd1;  plan[3].mid = 8'd255;
    foreach (plan[i]) begin
      apply_settings(plan[i]);
      run_random(55, 1'b1, 1'b1);
    end
  endtask

  task automatic test_launch_run();
    settings_t s;
    s = default_settings();
    s.thr = 15'd1000;
    s.run_req = 4'd5;
    s.flight_ms = 32'hFFFF_FFFF;
    s.calib_ms = 32'd100;
    s.log_ms = 16'd3;
    apply_settings(s);
    send_tick(make_tick(clock_ms + 32'd1, 0, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_tick(make_tick(clock_ms + 32'd1, 1001, 0, 0, 0, 0));
    send_tick(make_tick(clock_ms + 32'd1, 1000, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send_tick(make_tick(clock_ms + 32'd1, -300, -1001, 7, 0, 0));
    send_tick(make_tick(clock_ms + 32'd1, 0, 0, -1001, 32767, -32768));
    send_tick(make_tick(clock_ms + 32'd1, 0, 0, 0, 100, -100));
  endtask

  task automatic test_flight_servo();
    settings_t plan[5];
    foreach (plan[i]) begin
      plan[i] = default_settings();
      plan[i].flight_ms = 32'hFFFF_FFFF;
    end
    plan[0].gain = 8'd255; plan[0].mid = 8'd90;  plan[0].deflect = 7'd90;
    plan[1].gain = 8'd0;   plan[1].mid = 8'd180; plan[1].deflect = 7'd127;
    plan[2].gain = 8'd200; plan[2].mid = 8'd0;   plan[2].deflect = 7'd127;
    plan[2].log_ms = 16'd0;
    plan[3].gain = 8'd16;  plan[3].mid = 8'd255; plan[3].deflect = 7'd0;
    plan[4].gain = 8'd137; plan[4].mid = 8'd45;  plan[4].deflect = 7'd60;
    plan[4].log_ms = 16'd2;
    foreach (plan[i]) begin
      apply_settings(plan[i]);
      run_random(45, 1'b0, 1'b1);
    end
  endtask

  task automatic test_flight_end();
    settings_t s;
    s = default_settings();
    s.flight_ms = clock_ms - launch_at + 32'd25;
    s.log_ms = 16'd4;
    s.gain = 8'd180;
    apply_settings(s);
    run_random(45, 1'b0, 1'b0);
  endtask

  task automatic test_after_flight();
    settings_t s;
    s = default_settings();
    s.thr = 15'd0;
    s.run_req = 4'd0;
    s.flight_ms = 32'd0;
    s.calib_ms = 32'd0;
    s.log_ms = 16'hFFFF;
    s.gain = 8'd255;
    s.mid = 8'd180;
    s.deflect = 7'd90;
    apply_settings(s);
    run_random(30, 1'b0, 1'b1);
    s = default_settings();
    s.log_ms = 16'd2;
    s.mid = 8'd7;
    apply_settings(s);
    run_random(30, 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("result transaction with no tick pending");
          failures++;
        end else begin
          head = status_due.pop_front();
          check_field("servo_x", head.servo_x, servo_x);
          check_field("servo_y", head.servo_y, servo_y);
          check_field("launch_seen", 8'(head.launch_seen), 8'(launch_seen));
          check_field("in_flight", 8'(head.in_flight), 8'(in_flight));
          check_field("start_logging", 8'(head.start_logging), 8'(start_logging));
          check_field("stop_logging", 8'(head.stop_logging), 8'(stop_logging));
          check_field("calib_request", 8'(head.calib_request), 8'(calib_request));
          check_field("log_strobe", 8'(head.log_strobe), 8'(log_strobe));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    regs = default_settings();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 88;
    test_prelaunch_directed();
    test_prelaunch_random();
    send_idle_pct = 88;
    recv_idle_pct = 20;
    test_launch_run();
    test_flight_servo();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_flight_end();
    test_after_flight();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d expected results never arrived", status_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
